// ===== design/orbfm_pkg.sv =====
// Shared widths and types for the orbital frame matrix pipeline.
`default_nettype none

package orbfm_pkg;

    localparam int POS_W  = 28;
    localparam int VEL_W  = 25;
    localparam int Z_W    = 29;
    localparam int Y_W    = 55;
    localparam int YS_W   = 32;
    localparam int X_W    = 62;
    localparam int MAG_W  = 31;
    localparam int ELEM_W = 32;
    localparam int IN_W   = 160;
    localparam int OUT_W  = 9 * ELEM_W;

    // Block-scaled vector: magnitudes with top in [2^30, 2^31), signs, zero flag
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
    } svec_t;

endpackage

`default_nettype wire

// ===== design/orbital_frame_matrix_top.sv =====
// Throughput: one item per cycle; the pipeline advances as one, stalled only when
//   the output register holds an untaken result and the last stage is full.
// Depth is set by the bit-serial square root (32 stages) and the restoring
//   dividers (FRAC_BITS + 3 stages, set-up included).
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
`default_nettype none

module orbital_frame_matrix_top
    import orbfm_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z from bit 0 up, one pad bit
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    output logic [OUT_W-1:0] m_tdata,
    // zero_error
    output logic             m_tuser
);

    logic adv;

    logic                    vld0_reg;
    logic signed [Z_W-1:0]   zd_reg [6][3];
    logic signed [VEL_W-1:0] v_reg [3];

    logic                    y_vld;
    logic signed [Y_W-1:0]   y_vec [3];
    logic                    ys_vld;
    svec_t                   zs, ys;
    svec_t                   zs_d_reg [5];
    svec_t                   ys_d_reg [5];
    logic signed [YS_W-1:0]  ys_sv [3];

    logic                    x_vld;
    logic signed [X_W-1:0]   x_vec [3];
    logic                    xs_vld;
    svec_t                   xs;
    logic                    err;

    logic                    u_vld, u_clr;
    logic signed [ELEM_W-1:0] ux [3];
    logic signed [ELEM_W-1:0] uy [3];
    logic signed [ELEM_W-1:0] uz [3];

    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic                    m_tuser_reg;

    assign adv      = !u_vld || !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (adv) begin
            vld0_reg <= s_tvalid;
        end
    end

    // z is the negated position, one bit wider
    always_ff @(posedge aclk) begin
        if (adv) begin
            zd_reg[0][0] <= -{s_tdata[POS_W-1], s_tdata[POS_W-1:0]};
            zd_reg[0][1] <= -{s_tdata[2*POS_W-1], s_tdata[2*POS_W-1:POS_W]};
            zd_reg[0][2] <= -{s_tdata[3*POS_W-1], s_tdata[3*POS_W-1:2*POS_W]};
            v_reg[0]     <= s_tdata[3*POS_W +: VEL_W];
            v_reg[1]     <= s_tdata[3*POS_W+VEL_W +: VEL_W];
            v_reg[2]     <= s_tdata[3*POS_W+2*VEL_W +: VEL_W];
            for (int i = 1; i < 6; i++) begin
                zd_reg[i] <= zd_reg[i-1];
            end
            zs_d_reg[0] <= zs;
            ys_d_reg[0] <= ys;
            for (int i = 1; i < 5; i++) begin
                zs_d_reg[i] <= zs_d_reg[i-1];
                ys_d_reg[i] <= ys_d_reg[i-1];
            end
        end
    end

    orbfm_cross #(.AW(Z_W), .BW(VEL_W)) u_cross_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (vld0_reg),
        .a       (zd_reg[0]),
        .b       (v_reg),
        .vld_o   (y_vld),
        .r       (y_vec)
    );

    orbfm_norm #(.W(Z_W)) u_norm_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (y_vld),
        .v       (zd_reg[2]),
        .vld_o   (),
        .o       (zs)
    );

    orbfm_norm #(.W(Y_W)) u_norm_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (y_vld),
        .v       (y_vec),
        .vld_o   (ys_vld),
        .o       (ys)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ys_sv[k] = ys.neg[k] ? -{1'b0, ys.mag[k]} : {1'b0, ys.mag[k]};
        end
    end

    orbfm_cross #(.AW(YS_W), .BW(Z_W)) u_cross_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (ys_vld),
        .a       (ys_sv),
        .b       (zd_reg[5]),
        .vld_o   (x_vld),
        .r       (x_vec)
    );

    orbfm_norm #(.W(X_W)) u_norm_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (x_vld),
        .v       (x_vec),
        .vld_o   (xs_vld),
        .o       (xs)
    );

    assign err = zs_d_reg[4].zero | ys_d_reg[4].zero | xs.zero;

    orbfm_unit #(.FB(FRAC_BITS)) u_unit_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (xs_vld),
        .clr_i   (err),
        .w_i     (xs),
        .vld_o   (u_vld),
        .clr_o   (u_clr),
        .elem_o  (ux)
    );

    orbfm_unit #(.FB(FRAC_BITS)) u_unit_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (xs_vld),
        .clr_i   (err),
        .w_i     (ys_d_reg[4]),
        .vld_o   (),
        .clr_o   (),
        .elem_o  (uy)
    );

    orbfm_unit #(.FB(FRAC_BITS)) u_unit_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .vld_i   (xs_vld),
        .clr_i   (err),
        .w_i     (zs_d_reg[4]),
        .vld_o   (),
        .clr_o   (),
        .elem_o  (uz)
    );

    // load on a full last stage, drop the result once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            if (u_vld) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && u_vld) begin
            m_tdata_reg <= {uz[2], uy[2], ux[2],
                            uz[1], uy[1], ux[1],
                            uz[0], uy[0], ux[0]};
            m_tuser_reg <= u_clr;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== design/orbfm_cross.sv =====
// Two-stage pipelined cross product of two signed 3-vectors.
`default_nettype none

module orbfm_cross
    import orbfm_pkg::*;
#(
    parameter int AW = 29,
    parameter int BW = 25
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     vld_i,
    input  logic signed [AW-1:0]     a [3],
    input  logic signed [BW-1:0]     b [3],
    output logic                     vld_o,
    output logic signed [AW+BW:0]    r [3]
);

    localparam int PW = AW + BW;
    localparam int RW = AW + BW + 1;

    logic signed [PW-1:0] prod_reg [6];
    logic signed [PW-1:0] prod_next [6];
    logic signed [RW-1:0] r_reg [3];
    logic                 vld_p_reg;
    logic                 vld_r_reg;

    always_comb begin
        prod_next[0] = a[1] * b[2];
        prod_next[1] = a[2] * b[1];
        prod_next[2] = a[2] * b[0];
        prod_next[3] = a[0] * b[2];
        prod_next[4] = a[0] * b[1];
        prod_next[5] = a[1] * b[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_p_reg <= 1'b0;
            vld_r_reg <= 1'b0;
        end else if (en) begin
            vld_p_reg <= vld_i;
            vld_r_reg <= vld_p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            for (int k = 0; k < 3; k++) begin
                r_reg[k] <= RW'(prod_reg[2*k]) - RW'(prod_reg[2*k+1]);
            end
        end
    end

    assign vld_o = vld_r_reg;
    assign r     = r_reg;

endmodule

`default_nettype wire

// ===== design/orbfm_norm.sv =====
// Three-stage block scaler: magnitude, leading-one search, common shift.
`default_nettype none

module orbfm_norm
    import orbfm_pkg::*;
#(
    parameter int W = 55
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_i,
    input  logic signed [W-1:0] v [3],
    output logic                vld_o,
    output svec_t               o
);

    localparam int PW = $clog2(W);
    localparam int SW = W + MAG_W - 1;

    logic [W-1:0]  mag_reg [3];
    logic [2:0]    neg_reg;
    logic [W-1:0]  orv_reg;
    logic          vld_a_reg;

    logic [W-1:0]  mag_b_reg [3];
    logic [2:0]    neg_b_reg;
    logic [PW-1:0] pos_reg;
    logic          zero_reg;
    logic          vld_b_reg;
    logic [PW-1:0] pos_next;

    svec_t         o_reg;
    logic          vld_c_reg;

    always_comb begin
        pos_next = '0;
        for (int i = 0; i < W; i++) begin
            if (orv_reg[i]) pos_next = PW'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= vld_i;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [W-1:0] m;
        logic [W-1:0] acc;
        logic [SW-1:0] wide;
        if (en) begin
            acc = '0;
            for (int k = 0; k < 3; k++) begin
                m = v[k][W-1] ? W'(-v[k]) : W'(v[k]);
                mag_reg[k] <= m;
                neg_reg[k] <= v[k][W-1];
                acc = acc | m;
            end
            orv_reg <= acc;

            mag_b_reg <= mag_reg;
            neg_b_reg <= neg_reg;
            pos_reg   <= pos_next;
            zero_reg  <= (orv_reg == '0);

            // place the leading one of the largest magnitude at bit 30
            for (int k = 0; k < 3; k++) begin
                wide = {mag_b_reg[k], {(MAG_W-1){1'b0}}} >> pos_reg;
                o_reg.mag[k] <= wide[MAG_W-1:0];
            end
            o_reg.neg  <= neg_b_reg;
            o_reg.zero <= zero_reg;
        end
    end

    assign vld_o = vld_c_reg;
    assign o     = o_reg;

endmodule

`default_nettype wire

// ===== design/orbfm_unit.sv =====
// Unit-vector pipeline: sum of squares, bit-serial root, three rounding dividers.
`default_nettype none

module orbfm_unit
    import orbfm_pkg::*;
#(
    parameter int FB = 30
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     vld_i,
    input  logic                     clr_i,
    input  svec_t                    w_i,
    output logic                     vld_o,
    output logic                     clr_o,
    output logic signed [ELEM_W-1:0] elem_o [3]
);

    localparam int SQ_N = 32;
    localparam int RMW  = 35;
    localparam int QW   = FB + 2;
    localparam int NW   = FB + 32;
    localparam int DN   = QW + 1;

    // squares and sum
    logic [2*MAG_W-1:0] sq_reg [3];
    svec_t              w0_reg;
    logic               clr0_reg, vld0_reg;
    logic [63:0]        sum_reg;
    svec_t              w1_reg;
    logic               clr1_reg, vld1_reg;

    // root stages
    logic [RMW-1:0]     rt_rem_reg  [SQ_N];
    logic [31:0]        rt_root_reg [SQ_N];
    logic [63:0]        rt_s_reg    [SQ_N];
    svec_t              rt_w_reg    [SQ_N];
    logic [SQ_N-1:0]    rt_clr_reg, rt_vld_reg;
    logic [RMW-1:0]     rt_rem_next  [SQ_N];
    logic [31:0]        rt_root_next [SQ_N];

    // divider stages: index 0 is the numerator set-up
    logic [31:0]        dv_rem_reg [DN][3];
    logic [QW-1:0]      dv_n_reg   [DN][3];
    logic [QW-1:0]      dv_q_reg   [DN][3];
    logic [31:0]        dv_l_reg   [DN];
    logic [2:0]         dv_neg_reg [DN];
    logic [DN-1:0]      dv_clr_reg, dv_vld_reg;
    logic [31:0]        dv_rem_next [DN][3];
    logic [QW-1:0]      dv_n_next   [DN][3];
    logic [QW-1:0]      dv_q_next   [DN][3];

    logic signed [ELEM_W-1:0] elem_reg [3];
    logic                     clr_f_reg, vld_f_reg;

    always_comb begin
        logic [RMW-1:0] prem;
        logic [31:0]    proot;
        logic [63:0]    ps;
        logic [RMW-1:0] bring;
        logic [RMW-1:0] trial;
        for (int j = 0; j < SQ_N; j++) begin
            if (j == 0) begin
                prem  = '0;
                proot = '0;
                ps    = sum_reg;
            end else begin
                prem  = rt_rem_reg[j-1];
                proot = rt_root_reg[j-1];
                ps    = rt_s_reg[j-1];
            end
            bring = {prem[RMW-3:0], ps[63-2*j -: 2]};
            trial = {1'b0, proot, 2'b01};
            if (bring >= trial) begin
                rt_rem_next[j]  = bring - trial;
                rt_root_next[j] = {proot[30:0], 1'b1};
            end else begin
                rt_rem_next[j]  = bring;
                rt_root_next[j] = {proot[30:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [31:0]   len;
        logic [NW-1:0] num;
        logic [32:0]   t;
        len = rt_root_reg[SQ_N-1];
        for (int k = 0; k < 3; k++) begin
            // numerator carries half the length for round-half-up
            num = (NW'(rt_w_reg[SQ_N-1].mag[k]) << FB) + NW'(len >> 1);
            dv_rem_next[0][k] = 32'(num[NW-1:QW]);
            dv_n_next[0][k]   = num[QW-1:0];
            dv_q_next[0][k]   = '0;
        end
        for (int i = 1; i < DN; i++) begin
            for (int k = 0; k < 3; k++) begin
                t = {dv_rem_reg[i-1][k], dv_n_reg[i-1][k][QW-1]};
                if (t >= {1'b0, dv_l_reg[i-1]}) begin
                    dv_rem_next[i][k] = 32'(t - {1'b0, dv_l_reg[i-1]});
                    dv_q_next[i][k]   = {dv_q_reg[i-1][k][QW-2:0], 1'b1};
                end else begin
                    dv_rem_next[i][k] = t[31:0];
                    dv_q_next[i][k]   = {dv_q_reg[i-1][k][QW-2:0], 1'b0};
                end
                dv_n_next[i][k] = {dv_n_reg[i-1][k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg   <= 1'b0;
            vld1_reg   <= 1'b0;
            rt_vld_reg <= '0;
            dv_vld_reg <= '0;
            vld_f_reg  <= 1'b0;
        end else if (en) begin
            vld0_reg   <= vld_i;
            vld1_reg   <= vld0_reg;
            rt_vld_reg <= {rt_vld_reg[SQ_N-2:0], vld1_reg};
            dv_vld_reg <= {dv_vld_reg[DN-2:0], rt_vld_reg[SQ_N-1]};
            vld_f_reg  <= dv_vld_reg[DN-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic [QW-1:0] q;
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= w_i.mag[k] * w_i.mag[k];
            end
            w0_reg   <= w_i;
            clr0_reg <= clr_i;

            sum_reg  <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            w1_reg   <= w0_reg;
            clr1_reg <= clr0_reg;

            for (int j = 0; j < SQ_N; j++) begin
                rt_rem_reg[j]  <= rt_rem_next[j];
                rt_root_reg[j] <= rt_root_next[j];
            end
            rt_s_reg[0] <= sum_reg;
            rt_w_reg[0] <= w1_reg;
            for (int j = 1; j < SQ_N; j++) begin
                rt_s_reg[j] <= rt_s_reg[j-1];
                rt_w_reg[j] <= rt_w_reg[j-1];
            end
            rt_clr_reg <= {rt_clr_reg[SQ_N-2:0], clr1_reg};

            dv_rem_reg    <= dv_rem_next;
            dv_n_reg      <= dv_n_next;
            dv_q_reg      <= dv_q_next;
            dv_l_reg[0]   <= rt_root_reg[SQ_N-1];
            dv_neg_reg[0] <= rt_w_reg[SQ_N-1].neg;
            for (int i = 1; i < DN; i++) begin
                dv_l_reg[i]   <= dv_l_reg[i-1];
                dv_neg_reg[i] <= dv_neg_reg[i-1];
            end
            dv_clr_reg <= {dv_clr_reg[DN-2:0], rt_clr_reg[SQ_N-1]};

            // apply sign, force zero on a degenerate frame
            for (int k = 0; k < 3; k++) begin
                q = dv_q_reg[DN-1][k];
                if (dv_clr_reg[DN-1]) begin
                    elem_reg[k] <= '0;
                end else if (dv_neg_reg[DN-1][k]) begin
                    elem_reg[k] <= ELEM_W'(0) - ELEM_W'(q);
                end else begin
                    elem_reg[k] <= ELEM_W'(q);
                end
            end
            clr_f_reg <= dv_clr_reg[DN-1];
        end
    end

    assign vld_o  = vld_f_reg;
    assign clr_o  = clr_f_reg;
    assign elem_o = elem_reg;

endmodule

`default_nettype wire

// ===== design/orbfm_chk.sv =====
// Port-level checker for the orbital frame matrix, bound to the top level.
`default_nettype none

module orbfm_chk
    import orbfm_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    localparam logic signed [ELEM_W:0] LIM = (ELEM_W+1)'(1) <<< FRAC_BITS;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate frame with nonzero elements");

    a_elem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed({m_tdata[ELEM_W-1], m_tdata[ELEM_W-1:0]}) <= LIM
                  && $signed({m_tdata[ELEM_W-1], m_tdata[ELEM_W-1:0]}) >= -LIM
                  && $signed({m_tdata[OUT_W-1], m_tdata[OUT_W-1 -: ELEM_W]}) <= LIM
                  && $signed({m_tdata[OUT_W-1], m_tdata[OUT_W-1 -: ELEM_W]}) >= -LIM)
        else $error("matrix element beyond unit magnitude");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind orbital_frame_matrix_top orbfm_chk #(.FRAC_BITS(FRAC_BITS)) u_orbfm_chk (.*);

`default_nettype wire
